FILE: design/rcat_pkg.sv
// Package for the rotation compose and transform unit.
// Holds word types, operation and axis codes, the CORDIC arctangent table.
// No dependencies.
package rcat_pkg;

    localparam int ATAN_LEN = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ENT_W = 18;
    localparam logic [23:0] SCALE_RESET = 24'd65536;
    localparam logic signed [ENT_W-1:0] ONE_Q16 = 18'sd65536;
    localparam logic signed [ENT_W-1:0] ENT_MAX = 18'sd131071;
    localparam logic signed [ENT_W-1:0] ENT_MIN = -18'sd131072;

    typedef enum logic [1:0] {
        OP_IDENT = 2'd0,
        OP_ROT   = 2'd1,
        OP_XFORM = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         axis;
        logic signed [15:0] angle;
        logic signed [23:0] in_x;
        logic signed [23:0] in_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic ident;
        logic cord_init;
        logic cord_step;
        logic cord_fin;
        logic mac_start;
        logic mac_run;
        logic commit;
        logic t_mul0;
        logic t_mul1;
        logic t_sum;
        logic t_scl;
        logic t_rnd;
        logic row;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cord_done;
        logic mac_done;
    } t_sts;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'h20000000;
            5'd1:  atan_turn = 32'h12E4051D;
            5'd2:  atan_turn = 32'h09FB385B;
            5'd3:  atan_turn = 32'h051111D4;
            5'd4:  atan_turn = 32'h028B0D43;
            5'd5:  atan_turn = 32'h0145D7E1;
            5'd6:  atan_turn = 32'h00A2F61E;
            5'd7:  atan_turn = 32'h00517C55;
            5'd8:  atan_turn = 32'h0028BE53;
            5'd9:  atan_turn = 32'h00145F2F;
            5'd10: atan_turn = 32'h000A2F98;
            5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6;
            5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2F9;
            5'd15: atan_turn = 32'h0000517C;
            5'd16: atan_turn = 32'h000028BE;
            5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A2F;
            5'd19: atan_turn = 32'h00000517;
            5'd20: atan_turn = 32'h0000028B;
            5'd21: atan_turn = 32'h00000145;
            5'd22: atan_turn = 32'h000000A2;
            5'd23: atan_turn = 32'h00000051;
            default: atan_turn = 32'h0;
        endcase
    endfunction

endpackage

FILE: design/rcat_ctrl.sv
// Controller state machine of the rotation compose and transform unit.
// Sequences the datapath through commands; depends on rcat_pkg.
module rcat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_op,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rcat_pkg::t_sts i_sts,
    output rcat_pkg::t_cmd o_cmd
);
    import rcat_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CORD   = 11'b000_0000_0010,
        S_CFIN   = 11'b000_0000_0100,
        S_MACST  = 11'b000_0000_1000,
        S_MAC    = 11'b000_0001_0000,
        S_COMMIT = 11'b000_0010_0000,
        S_TM0    = 11'b000_0100_0000,
        S_TM1    = 11'b000_1000_0000,
        S_TSUM   = 11'b001_0000_0000,
        S_TSCL   = 11'b010_0000_0000,
        S_TRND   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_row, n_row;
    logic   r_ov, n_ov;
    logic   r_wait, n_wait;
    logic   accept;

    assign o_in_stall  = (r_state != S_IDLE) || r_wait;
    assign o_out_valid = r_ov;
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_wait  = r_wait;
        n_ov    = r_ov && i_out_stall;
        o_cmd   = '0;
        o_cmd.row = r_row;
        case (r_state)
            S_IDLE: begin
                if (r_wait) begin
                    if (!r_ov || !i_out_stall) begin
                        o_cmd.out_load = 1'b1;
                        n_ov   = 1'b1;
                        n_wait = 1'b0;
                    end
                end else if (accept) begin
                    o_cmd.accept = 1'b1;
                    case (t_op'(i_op))
                        OP_IDENT: o_cmd.ident = 1'b1;
                        OP_ROT:   n_state = S_CORD;
                        OP_XFORM: begin
                            n_state = S_TM0;
                            n_row   = 1'b0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                if (i_sts.cord_done) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.cord_fin = 1'b1;
                n_state = S_MACST;
            end
            S_MACST: begin
                o_cmd.mac_start = 1'b1;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac_run = 1'b1;
                if (i_sts.mac_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            S_TM0: begin
                o_cmd.t_mul0 = 1'b1;
                n_state = S_TM1;
            end
            S_TM1: begin
                o_cmd.t_mul1 = 1'b1;
                n_state = S_TSUM;
            end
            S_TSUM: begin
                o_cmd.t_sum = 1'b1;
                n_state = S_TSCL;
            end
            S_TSCL: begin
                o_cmd.t_scl = 1'b1;
                n_state = S_TRND;
            end
            S_TRND: begin
                o_cmd.t_rnd = 1'b1;
                if (r_row) begin
                    n_state = S_IDLE;
                    n_wait  = 1'b1;
                end else begin
                    n_row   = 1'b1;
                    n_state = S_TM0;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.cord_init = o_cmd.accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= 1'b0;
            r_ov    <= 1'b0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_ov    <= n_ov;
            r_wait  <= n_wait;
        end
    end

endmodule

FILE: design/rcat_dp.sv
// Datapath of the rotation compose and transform unit: matrix registers,
// CORDIC, shared multiplier and accumulators. Depends on rcat_pkg.
module rcat_dp #(
    parameter int CORDIC_STEPS = rcat_pkg::DEF_CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcat_pkg::t_cmd      i_cmd,
    output rcat_pkg::t_sts      o_sts,
    input  rcat_pkg::t_in_word  i_in_word,
    input  logic                i_cfg_we,
    input  logic [23:0]         i_cfg_wdata,
    output rcat_pkg::t_out_word o_out_word
);
    import rcat_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);

    logic [23:0]               r_scale;
    t_in_word                  r_in;
    logic signed [ENT_W-1:0]   r_m [9];
    logic signed [ENT_W-1:0]   r_nm [9];

    logic signed [33:0]        r_x, r_y, r_z;
    logic [4:0]                r_ci;
    logic                      r_neg;
    logic signed [ENT_W-1:0]   r_sin, r_cos;

    logic [1:0]                r_mr, r_mk, r_mj;
    logic [4:0]                r_mcnt;
    logic                      r_pv;
    logic [1:0]                r_pj;
    logic [3:0]                r_pe;
    logic signed [37:0]        r_acc;

    logic signed [41:0]        r_prod;
    logic signed [42:0]        r_t;
    logic signed [55:0]        r_a, r_b;
    logic signed [31:0]        r_ox, r_oy;
    logic                      r_sat;

    logic [3:0]                rd_addr;
    logic signed [ENT_W-1:0]   m_rd;
    logic signed [23:0]        mul_b;
    logic signed [ENT_W-1:0]   e_val;
    logic [3:0]                e_idx;
    logic signed [16:0]        fold_ang;
    logic                      fold_neg;
    logic signed [33:0]        x_sh, y_sh, z_at;
    logic signed [19:0]        c_rnd, s_rnd;
    logic signed [20:0]        c_fix, s_fix;
    logic signed [37:0]        acc_sum, acc_rnd;
    logic signed [67:0]        full;
    logic signed [35:0]        res;
    logic                      res_hi, res_lo;
    logic signed [31:0]        res_sat;

    function automatic logic signed [ENT_W-1:0] clamp18(input logic signed [37:0] v);
        if (v > 38'(ENT_MAX)) begin
            clamp18 = ENT_MAX;
        end else if (v < 38'(ENT_MIN)) begin
            clamp18 = ENT_MIN;
        end else begin
            clamp18 = v[ENT_W-1:0];
        end
    endfunction

    always_comb begin
        e_idx = 4'(r_mr) * 4'd3 + 4'(r_mj);
        e_val = (e_idx == 4'd0 || e_idx == 4'd4 || e_idx == 4'd8) ? ONE_Q16 : '0;
        case (r_in.axis)
            AXIS_X: begin
                case (e_idx)
                    4'd4, 4'd8: e_val = r_cos;
                    4'd5:       e_val = -r_sin;
                    4'd7:       e_val = r_sin;
                    default:    e_val = e_val;
                endcase
            end
            AXIS_Y: begin
                case (e_idx)
                    4'd0, 4'd8: e_val = r_cos;
                    4'd2:       e_val = -r_sin;
                    4'd6:       e_val = r_sin;
                    default:    e_val = e_val;
                endcase
            end
            AXIS_Z: begin
                case (e_idx)
                    4'd0, 4'd4: e_val = r_cos;
                    4'd1:       e_val = -r_sin;
                    4'd3:       e_val = r_sin;
                    default:    e_val = e_val;
                endcase
            end
            default: e_val = e_val;
        endcase
    end

    always_comb begin
        if (i_cmd.t_mul0) begin
            rd_addr = i_cmd.row ? 4'd3 : 4'd0;
            mul_b   = r_in.in_x;
        end else if (i_cmd.t_mul1) begin
            rd_addr = i_cmd.row ? 4'd4 : 4'd1;
            mul_b   = r_in.in_y;
        end else begin
            rd_addr = 4'(r_mj) * 4'd3 + 4'(r_mk);
            mul_b   = 24'(e_val);
        end
        m_rd = r_m[rd_addr];
    end

    always_comb begin
        fold_ang = 17'(r_in.angle);
        fold_neg = 1'b0;
        if (r_in.angle > 16'sd16384) begin
            fold_ang = 17'(r_in.angle) - 17'sd32768;
            fold_neg = 1'b1;
        end else if (r_in.angle < -16'sd16384) begin
            fold_ang = 17'(r_in.angle) + 17'sd32768;
            fold_neg = 1'b1;
        end
        x_sh  = r_x >>> r_ci;
        y_sh  = r_y >>> r_ci;
        z_at  = 34'(atan_turn(r_ci));
        c_rnd = 20'((r_x + 34'sd8192) >>> 14);
        s_rnd = 20'((r_y + 34'sd8192) >>> 14);
        c_fix = r_neg ? -21'(c_rnd) : 21'(c_rnd);
        s_fix = r_neg ? -21'(s_rnd) : 21'(s_rnd);
        acc_sum = ((r_pj == 2'd0) ? 38'sd0 : r_acc) + 38'(r_prod);
        acc_rnd = (acc_sum + 38'sd32768) >>> 16;
        full    = (68'(r_a) <<< 12) + 68'(r_b) + 68'sd2147483648;
        res     = 36'(full >>> 32);
        res_hi  = res > 36'sd2147483647;
        res_lo  = res < -36'sd2147483648;
        res_sat = res_hi ? 32'sh7FFFFFFF : (res_lo ? 32'sh80000000 : res[31:0]);
    end

    assign o_sts.cord_done = (r_ci == LAST_STEP);
    assign o_sts.mac_done  = (r_mcnt == 5'd27);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.ident) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= (i % 4 == 0) ? ONE_Q16 : '0;
            end
        end else if (i_cmd.commit) begin
            for (int i = 0; i < 9; i++) begin
                r_m[i] <= r_nm[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_word;
        end
        if (i_cmd.cord_init) begin
            r_ci <= '0;
        end
        if (i_cmd.cord_step && r_ci == 5'd0) begin
            r_neg <= fold_neg;
        end
        if (i_cmd.cord_step) begin
            if (r_ci == 5'd0) begin
                if (fold_ang >= 0) begin
                    r_x <= 34'sh26DD3B6A;
                    r_y <= 34'sh26DD3B6A;
                    r_z <= (34'(fold_ang) <<< 16) - z_at;
                end else begin
                    r_x <= 34'sh26DD3B6A;
                    r_y <= -34'sh26DD3B6A;
                    r_z <= (34'(fold_ang) <<< 16) + z_at;
                end
            end else if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - z_at;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + z_at;
            end
            r_ci <= r_ci + 5'd1;
        end
        if (i_cmd.cord_fin) begin
            r_cos <= clamp18(38'(c_fix));
            r_sin <= clamp18(38'(s_fix));
        end
        if (i_cmd.mac_start) begin
            r_mr   <= '0;
            r_mk   <= '0;
            r_mj   <= '0;
            r_mcnt <= '0;
            r_pv   <= 1'b0;
        end
        if (i_cmd.mac_run) begin
            r_mcnt <= r_mcnt + 5'd1;
            r_pv   <= (r_mcnt != 5'd27);
            if (r_mcnt != 5'd27) begin
                r_prod <= m_rd * mul_b;
                r_pj   <= r_mj;
                r_pe   <= 4'(r_mr) * 4'd3 + 4'(r_mk);
                if (r_mj == 2'd2) begin
                    r_mj <= '0;
                    if (r_mk == 2'd2) begin
                        r_mk <= '0;
                        r_mr <= r_mr + 2'd1;
                    end else begin
                        r_mk <= r_mk + 2'd1;
                    end
                end else begin
                    r_mj <= r_mj + 2'd1;
                end
            end
            if (r_pv) begin
                r_acc <= acc_sum;
                if (r_pj == 2'd2) begin
                    r_nm[r_pe] <= clamp18(acc_rnd);
                end
            end
        end
        if (i_cmd.t_mul0 || i_cmd.t_mul1) begin
            r_prod <= m_rd * mul_b;
        end
        if (i_cmd.t_mul1) begin
            r_t <= 43'(r_prod);
        end
        if (i_cmd.t_sum) begin
            r_t <= r_t + 43'(r_prod);
        end
        if (i_cmd.t_scl) begin
            r_a <= 56'(r_t * $signed({1'b0, r_scale[23:12]}));
            r_b <= 56'(r_t * $signed({1'b0, r_scale[11:0]}));
        end
        if (i_cmd.t_rnd) begin
            if (i_cmd.row) begin
                r_oy  <= res_sat;
                r_sat <= r_sat | res_hi | res_lo;
            end else begin
                r_ox  <= res_sat;
                r_sat <= res_hi | res_lo;
            end
        end
        if (i_cmd.out_load) begin
            o_out_word.out_x     <= r_ox;
            o_out_word.out_y     <= r_oy;
            o_out_word.saturated <= r_sat;
        end
    end

endmodule

FILE: design/rotation_compose_and_transform_unit.sv
// Top level of the rotation compose and transform unit.
// Joins rcat_ctrl and rcat_dp; depends on rcat_pkg.
//
//  channel  direction  handshake                 word
//  in       input      i_in_valid / o_in_stall   i_in_word  (t_in_word)
//  out      output     o_out_valid / i_out_stall o_out_word (t_out_word)
//  cfg      input      i_cfg_we                  i_cfg_wdata (system scale)
//
// A reset-matrix word sets the matrix to identity. A rotation runs CORDIC_STEPS
// (at most 24) CORDIC steps, a finishing step, the 27 products of the single
// shared multiplier and a commit. Each of the two rows of a transform takes two
// products on that multiplier, a sum, a scale and a round, then a result load.
// Reset is synchronous; the matrix returns to identity and the scale to 1.0.
// A result held under i_out_stall stalls the input once the next transform ends.
module rotation_compose_and_transform_unit #(
    parameter int CORDIC_STEPS = rcat_pkg::DEF_CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rcat_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rcat_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [23:0]         i_cfg_wdata
);
    import rcat_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rcat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_in_word.op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcat_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_word  (o_out_word)
    );

    a_rot_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.op == OP_ROT) |=> o_in_stall)
        else $error("rotation word did not occupy the unit");

    a_xform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.op == OP_XFORM) |=> o_in_stall)
        else $error("transform word did not occupy the unit");

    a_ident_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.op == OP_IDENT) |=> !o_in_stall)
        else $error("reset-matrix word stalled the input");

endmodule
